### src/rgbhsv_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rgbhsv_pkg
// Types and constants shared by the RGB to HSV conversion pipeline.
// ----------------------------------------------------------------------------
package rgbhsv_pkg;

	localparam int unsigned CH_W       = 8;   // color channel width
	localparam int unsigned HUE_W      = 9;   // hue in degrees
	localparam int unsigned PCT_W      = 7;   // percent fields
	localparam int unsigned HNUM_W     = 17;  // hue numerator, up to 360*255+254
	localparam int unsigned SNUM_W     = 15;  // percent numerators, up to 25754
	localparam int unsigned HDIFF_W    = 16;  // 60 times a signed channel difference
	localparam int unsigned SECT_OFF_W = 9;   // sector offset in degrees
	localparam int unsigned DIV_STAGES = HUE_W; // one quotient bit per stage
	localparam int unsigned VAL_SH     = 8;   // divide by 255 via shift-and-fold

	localparam logic signed [HDIFF_W-1:0] HUE_SLOPE   = HDIFF_W'(60);
	localparam logic [SECT_OFF_W-1:0]     OFF_RED     = SECT_OFF_W'(0);
	localparam logic [SECT_OFF_W-1:0]     OFF_GREEN   = SECT_OFF_W'(120);
	localparam logic [SECT_OFF_W-1:0]     OFF_BLUE    = SECT_OFF_W'(240);
	localparam logic [SECT_OFF_W-1:0]     OFF_WRAP    = SECT_OFF_W'(360);
	localparam logic [HUE_W-1:0]          HUE_WRAP    = HUE_W'(360);
	localparam logic [SNUM_W-1:0]         PCT_SCALE   = SNUM_W'(100);
	localparam logic [SNUM_W-1:0]         VAL_ROUNDUP = SNUM_W'(254);

	typedef struct packed {
		logic [CH_W-1:0] red;
		logic [CH_W-1:0] green;
		logic [CH_W-1:0] blue;
	} rgb_t;

	typedef struct packed {
		logic [HUE_W-1:0] hue;
		logic [PCT_W-1:0] saturation;
		logic [PCT_W-1:0] brightness;
	} hsv_t;

	// Channel that holds the maximum
	typedef enum logic [1:0] {
		SECT_RED,
		SECT_GREEN,
		SECT_BLUE
	} hue_sect_t;

	// State carried through the shared-step divider stages
	typedef struct packed {
		logic [HNUM_W-1:0] hrem;
		logic [HUE_W-1:0]  hq;
		logic [CH_W-1:0]   hden;
		logic [SNUM_W-1:0] srem;
		logic [HUE_W-1:0]  sq;
		logic [CH_W-1:0]   sden;
		logic [PCT_W-1:0]  vq;
		logic              gray;
		logic              black;
	} div_t;

endpackage
`default_nettype wire

### src/rgb_to_hsv_converter_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rgb_to_hsv_converter_core
// Pipelined RGB to HSV conversion with ceiling-rounded integer results.
// ----------------------------------------------------------------------------
// Pipeline stages: 3 setup stages, 9 divider stages with one quotient bit
// each, 1 output register.
// Throughput: one pixel per cycle; the whole pipeline holds while the output
// register is full and not taken.
// Reset: arst_n clears every valid bit; payload registers are not reset.
module rgb_to_hsv_converter_core (
	input  wire                logic clk,
	input  wire                logic arst_n,
	input  wire                logic in_valid,
	output                     logic in_ready,
	input  wire rgbhsv_pkg::rgb_t in_data,
	output                     logic out_valid,
	input  wire                logic out_ready,
	output rgbhsv_pkg::hsv_t   out_data
);
	import rgbhsv_pkg::*;

	logic advance;

	// Stage 1: max, min, sector, signed difference
	logic                      valid_s1;
	logic [CH_W-1:0]           mx_s1;
	logic [CH_W-1:0]           delta_s1;
	hue_sect_t                 sect_s1;
	logic signed [CH_W:0]      diff_s1;

	// Stage 2: scaled numerators
	logic                      valid_s2;
	logic signed [HDIFF_W-1:0] hdiff_s2;
	logic [HNUM_W-1:0]         hoff_s2;
	logic [SNUM_W-1:0]         snum_s2;
	logic [SNUM_W-1:0]         vnum_s2;
	logic [CH_W-1:0]           mx_s2;
	logic [CH_W-1:0]           delta_s2;

	// Stage 3: final hue numerator, brightness quotient
	logic                      valid_s3;
	div_t                      div_s3;

	// Divider stages, index is the stage number
	logic                      div_valid_s [DIV_STAGES];
	div_t                      div_s       [DIV_STAGES];
	div_t                      div_in      [DIV_STAGES];
	div_t                      div_nxt     [DIV_STAGES];

	logic                      out_valid_q;
	hsv_t                      out_data_q;

	assign advance   = !out_valid_q || out_ready;
	assign in_ready  = advance;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// ------------------------------------------------------------------
	// Stage 1
	// ------------------------------------------------------------------
	logic [CH_W-1:0]      mx_c;
	logic [CH_W-1:0]      mn_c;
	hue_sect_t            sect_c;
	logic signed [CH_W:0] diff_c;

	always_comb begin
		logic signed [CH_W:0] r;
		logic signed [CH_W:0] g;
		logic signed [CH_W:0] b;
		r = $signed({1'b0, in_data.red});
		g = $signed({1'b0, in_data.green});
		b = $signed({1'b0, in_data.blue});

		mx_c = in_data.red;
		if (in_data.green > mx_c) mx_c = in_data.green;
		if (in_data.blue > mx_c) mx_c = in_data.blue;
		mn_c = in_data.red;
		if (in_data.green < mn_c) mn_c = in_data.green;
		if (in_data.blue < mn_c) mn_c = in_data.blue;

		// ties: blue first, then red, then green
		if (in_data.blue >= in_data.red && in_data.blue >= in_data.green) begin
			sect_c = SECT_BLUE;
			diff_c = r - g;
		end else if (in_data.red >= in_data.green) begin
			sect_c = SECT_RED;
			diff_c = g - b;
		end else begin
			sect_c = SECT_GREEN;
			diff_c = b - r;
		end
	end

	// ------------------------------------------------------------------
	// Stage 2
	// ------------------------------------------------------------------
	logic [SECT_OFF_W-1:0] off_c;
	logic signed [HDIFF_W-1:0] hdiff_c;
	logic [HNUM_W-1:0]     hoff_c;
	logic [SNUM_W-1:0]     snum_c;
	logic [SNUM_W-1:0]     vnum_c;

	always_comb begin
		unique case (sect_s1)
			SECT_BLUE:  off_c = OFF_BLUE;
			SECT_GREEN: off_c = OFF_GREEN;
			SECT_RED:   off_c = diff_s1[CH_W] ? OFF_WRAP : OFF_RED;
			default:    off_c = OFF_RED;
		endcase

		hdiff_c = HDIFF_W'(diff_s1) * HUE_SLOPE;

		// add delta - 1 so the floor divide rounds up
		if (delta_s1 == '0) begin
			hoff_c = '0;
		end else begin
			hoff_c = HNUM_W'(off_c) * HNUM_W'(delta_s1) + HNUM_W'(delta_s1)
				- HNUM_W'(1);
		end

		if (mx_s1 == '0) begin
			snum_c = '0;
		end else begin
			snum_c = SNUM_W'(delta_s1) * PCT_SCALE + SNUM_W'(mx_s1) - SNUM_W'(1);
		end

		vnum_c = SNUM_W'(mx_s1) * PCT_SCALE + VAL_ROUNDUP;
	end

	// ------------------------------------------------------------------
	// Stage 3
	// ------------------------------------------------------------------
	logic signed [HNUM_W:0] hsum_c;
	logic [SNUM_W:0]        vsum_c;
	div_t                   div_c;

	always_comb begin
		// numerator is never negative here
		hsum_c = $signed({1'b0, hoff_s2}) + (HNUM_W+1)'(hdiff_s2);
		// floor(x / 255) as (x + 1 + (x >> 8)) >> 8
		vsum_c = (SNUM_W+1)'(vnum_s2) + (SNUM_W+1)'(1)
			+ (SNUM_W+1)'(vnum_s2 >> VAL_SH);

		div_c.hrem  = hsum_c[HNUM_W-1:0];
		div_c.hq    = '0;
		div_c.hden  = delta_s2;
		div_c.srem  = snum_s2;
		div_c.sq    = '0;
		div_c.sden  = mx_s2;
		div_c.vq    = vsum_c[VAL_SH+PCT_W-1:VAL_SH];
		div_c.gray  = (delta_s2 == '0);
		div_c.black = (mx_s2 == '0);
	end

	// ------------------------------------------------------------------
	// Divider stages: restoring division, hue and saturation side by side
	// ------------------------------------------------------------------
	for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
		localparam int unsigned QBit = DIV_STAGES - 1 - k;

		if (k == 0) begin : g_first
			assign div_in[k] = div_s3;
		end else begin : g_next
			assign div_in[k] = div_s[k-1];
		end

		always_comb begin
			logic [HNUM_W-1:0] htrial;
			logic [SNUM_W-1:0] strial;
			htrial = HNUM_W'(div_in[k].hden) << QBit;
			strial = SNUM_W'(div_in[k].sden) << QBit;

			div_nxt[k] = div_in[k];
			if (div_in[k].hrem >= htrial) begin
				div_nxt[k].hrem    = div_in[k].hrem - htrial;
				div_nxt[k].hq[QBit] = 1'b1;
			end
			// saturation quotient never exceeds 100, so its top bits stay clear
			if (QBit < PCT_W && div_in[k].srem >= strial) begin
				div_nxt[k].srem    = div_in[k].srem - strial;
				div_nxt[k].sq[QBit] = 1'b1;
			end
		end

		always_ff @(posedge clk) begin
			if (advance) begin
				div_s[k] <= div_nxt[k];
			end
		end
	end

	for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div_valid
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				div_valid_s[k] <= 1'b0;
			end else if (advance) begin
				div_valid_s[k] <= (k == 0) ? valid_s3 : div_valid_s[(k == 0) ? 0 : k-1];
			end
		end
	end

	// ------------------------------------------------------------------
	// Output formatting
	// ------------------------------------------------------------------
	hsv_t out_c;

	always_comb begin
		// gray gives hue 0; a hue rounding up to 360 wraps to 0
		if (div_s[DIV_STAGES-1].gray || div_s[DIV_STAGES-1].hq == HUE_WRAP) begin
			out_c.hue = '0;
		end else begin
			out_c.hue = div_s[DIV_STAGES-1].hq;
		end
		out_c.saturation = div_s[DIV_STAGES-1].black ? '0
			: div_s[DIV_STAGES-1].sq[PCT_W-1:0];
		out_c.brightness = div_s[DIV_STAGES-1].vq;
	end

	// ------------------------------------------------------------------
	// Registers
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			valid_s1    <= in_valid;
			valid_s2    <= valid_s1;
			valid_s3    <= valid_s2;
			out_valid_q <= div_valid_s[DIV_STAGES-1];
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			mx_s1      <= mx_c;
			delta_s1   <= mx_c - mn_c;
			sect_s1    <= sect_c;
			diff_s1    <= diff_c;

			hdiff_s2   <= hdiff_c;
			hoff_s2    <= hoff_c;
			snum_s2    <= snum_c;
			vnum_s2    <= vnum_c;
			mx_s2      <= mx_s1;
			delta_s2   <= delta_s1;

			div_s3     <= div_c;

			out_data_q <= out_c;
		end
	end

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	a_hue_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> out_data_q.hue < HUE_WRAP)
		else $error("hue out of range");

	a_pct_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_data_q.saturation <= PCT_W'(100)
			&& out_data_q.brightness <= PCT_W'(100)))
		else $error("percent field out of range");

	a_black: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_data_q.brightness == '0) |->
			(out_data_q.saturation == '0 && out_data_q.hue == '0))
		else $error("black pixel with nonzero hue or saturation");

	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> valid_s1)
		else $error("transfer did not enter stage 1");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |=> ($stable(valid_s3) && $stable(div_s3)))
		else $error("pipeline moved during stall");

endmodule
`default_nettype wire
